/* rtl/scl_pkg.sv */
// Shared constants, token codes and payload types of the shell command lexer.
`default_nettype none
package scl_pkg;

   localparam int POS_WIDTH     = 16;
   localparam int OUT_POS_WIDTH = 16;
   localparam int KEYWORD_MAX   = 8;
   localparam int PUSH_MAX      = 3;

   localparam logic [5:0] T_WORD  = 6'd0;
   localparam logic [5:0] T_VAR   = 6'd1;
   localparam logic [5:0] T_DQ    = 6'd2;
   localparam logic [5:0] T_SQ    = 6'd3;
   localparam logic [5:0] T_GT    = 6'd4;
   localparam logic [5:0] T_LT    = 6'd5;
   localparam logic [5:0] T_GTGT  = 6'd6;
   localparam logic [5:0] T_SEMI  = 6'd7;
   localparam logic [5:0] T_LPAR  = 6'd8;
   localparam logic [5:0] T_RPAR  = 6'd9;
   localparam logic [5:0] T_LBRK  = 6'd10;
   localparam logic [5:0] T_RBRK  = 6'd11;
   localparam logic [5:0] T_LBRC  = 6'd12;
   localparam logic [5:0] T_RBRC  = 6'd13;
   localparam logic [5:0] T_PIPE  = 6'd14;
   localparam logic [5:0] T_OR    = 6'd15;
   localparam logic [5:0] T_AND   = 6'd16;
   localparam logic [5:0] T_NL    = 6'd17;
   localparam logic [5:0] T_EQ    = 6'd18;
   localparam logic [5:0] T_EQEQ  = 6'd19;
   localparam logic [5:0] T_NOT   = 6'd20;
   localparam logic [5:0] T_NOTEQ = 6'd21;
   localparam logic [5:0] T_KW0   = 6'd22;
   localparam logic [5:0] T_EOF   = 6'd34;

   typedef logic [POS_WIDTH-1:0] scl_pos_type;
   typedef logic [KEYWORD_MAX-1:0][7:0] scl_word_type;

   typedef struct packed {
      logic [5:0]               token_type;
      logic [OUT_POS_WIDTH-1:0] start_pos;
      logic [OUT_POS_WIDTH-1:0] end_pos;
      logic                     terminated;
      logic                     last;
   } scl_res_type;

   typedef struct packed {
      logic [1:0]                       count;
      scl_res_type [PUSH_MAX-1:0]       item;
   } scl_push_type;

endpackage
`default_nettype wire

/* rtl/scl_req_if.sv */
// Input channel: one character word or end mark per handshake.
`default_nettype none
interface scl_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] ch;

   modport source (output valid, output action, output ch, input ready);
   modport sink   (input valid, input action, input ch, output ready);
endinterface
`default_nettype wire

/* rtl/scl_rsp_if.sv */
// Result channel: one token word per handshake.
`default_nettype none
interface scl_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_type;
   logic [15:0] start_pos;
   logic [15:0] end_pos;
   logic        terminated;
   logic        last;

   modport source (output valid, output token_type, output start_pos, output end_pos,
                   output terminated, output last, input ready);
   modport sink   (input valid, input token_type, input start_pos, input end_pos,
                   input terminated, input last, output ready);
endinterface
`default_nettype wire

/* rtl/shell_command_lexer_top.sv */
// Top level of the shell command lexer: lexer core and token queue.
//
// Takes one input word per cycle (a character, or the end mark) while the token
// queue has room, and emits tokens as a type with start and end positions, one
// token per output handshake. Each input word is decoded in one pass of the lexer
// core; its tokens are written into the token queue when it is accepted and wait
// there for rsp. An input word yields zero to three tokens, so the input keeps up
// with the output at one word per cycle only while each word yields at most one
// token. The input is taken whenever the eight-entry token queue has room for three
// tokens, so it keeps flowing while a finished token waits on rsp. After the end
// mark the lexer is back in its reset state. No clearing pass follows reset.
`default_nettype none
module shell_command_lexer_top (
   input  wire logic clock,
   input  wire logic reset,
   scl_req_if.sink   req_bus,
   scl_rsp_if.source rsp_bus
);

   scl_pkg::scl_push_type push;
   logic                  space_ok;

   scl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .space_ok (space_ok),
      .push     (push)
   );

   scl_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_bus)
   );

endmodule
`default_nettype wire

/* rtl/scl_core.sv */
// Lexer state registers and the single-pass next-state and token logic.
`default_nettype none
module scl_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   scl_req_if.sink                    req,
   input  wire logic                  space_ok,
   output scl_pkg::scl_push_type      push
);

   localparam int PW = scl_pkg::POS_WIDTH;
   localparam int KM = scl_pkg::KEYWORD_MAX;
   localparam int KI = $clog2(KM);
   localparam int KW_COUNT = 12;
   localparam logic [3:0] WLEN_MAX = 4'd15;

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_WORD  = 3'd1;
   localparam logic [2:0] MODE_VAR   = 3'd2;
   localparam logic [2:0] MODE_STR   = 3'd3;
   localparam logic [2:0] MODE_LINE  = 3'd4;
   localparam logic [2:0] MODE_BLOCK = 3'd5;
   localparam logic [2:0] MODE_BSTAR = 3'd6;

   localparam logic [7:0] CH_NONE    = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   localparam int KW_LEN [KW_COUNT] = '{5, 3, 2, 4, 4, 4, 2, 2, 4, 4, 5, 8};
   localparam logic [7:0] KW_TEXT [KW_COUNT][KM] = '{
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "o", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", "c", "t", "i", "o", "n"}
   };

   function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
      return (&v) ? v : v + PW'(1);
   endfunction

   function automatic logic [15:0] clamp_out(input logic [PW-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic scl_pkg::scl_res_type mk(input logic [5:0] t, input logic [PW-1:0] s,
                                               input logic [PW-1:0] e, input logic term);
      scl_pkg::scl_res_type r;
      r.token_type = t;
      r.start_pos  = clamp_out(s);
      r.end_pos    = clamp_out(e);
      r.terminated = term;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic [5:0] keyword_type(input scl_pkg::scl_word_type wc,
                                               input logic [3:0] wl);
      logic [5:0] t;
      logic       hit;
      t = scl_pkg::T_WORD;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (wl == 4'(KW_LEN[k]));
         for (int i = 0; i < KM; i++) begin
            if (i < KW_LEN[k] && wc[i] != KW_TEXT[k][i]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            t = scl_pkg::T_KW0 + 6'(k);
         end
      end
      return t;
   endfunction

   function automatic logic [5:0] single_type(input logic [7:0] c);
      logic [5:0] t;
      unique case (c)
         CH_GT:     t = scl_pkg::T_GT;
         CH_LT:     t = scl_pkg::T_LT;
         CH_SEMI:   t = scl_pkg::T_SEMI;
         CH_LPAREN: t = scl_pkg::T_LPAR;
         CH_RPAREN: t = scl_pkg::T_RPAR;
         CH_LBRACK: t = scl_pkg::T_LBRK;
         CH_RBRACK: t = scl_pkg::T_RBRK;
         CH_LBRACE: t = scl_pkg::T_LBRC;
         CH_RBRACE: t = scl_pkg::T_RBRC;
         CH_PIPE:   t = scl_pkg::T_PIPE;
         CH_NL:     t = scl_pkg::T_NL;
         CH_EQ:     t = scl_pkg::T_EQ;
         CH_BANG:   t = scl_pkg::T_NOT;
         default:   t = scl_pkg::T_WORD;
      endcase
      return t;
   endfunction

   function automatic logic [5:0] double_type(input logic [7:0] c);
      logic [5:0] t;
      unique case (c)
         CH_EQ:   t = scl_pkg::T_EQEQ;
         CH_PIPE: t = scl_pkg::T_OR;
         CH_AMP:  t = scl_pkg::T_AND;
         CH_GT:   t = scl_pkg::T_GTGT;
         default: t = scl_pkg::T_WORD;
      endcase
      return t;
   endfunction

   function automatic logic is_var_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   logic [2:0]            mode_ff, mode_in;
   logic [7:0]            pend_ff, pend_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         tstart_ff, tstart_in;
   scl_pkg::scl_word_type wchars_ff, wchars_in;
   logic [3:0]            wlen_ff, wlen_in;
   logic                  qkind_ff, qkind_in;
   logic                  esc_ff, esc_in;

   logic                  fire;
   logic                  used;
   logic                  go;
   logic [PW-1:0]         idx;
   logic [7:0]            c;
   scl_pkg::scl_res_type  slot [scl_pkg::PUSH_MAX];
   logic [scl_pkg::PUSH_MAX-1:0] slot_v;
   logic [1:0]            n;
   scl_pkg::scl_res_type [scl_pkg::PUSH_MAX-1:0] items;

   assign req.ready = space_ok;
   assign fire      = req.valid & req.ready;
   assign c         = req.ch;

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      wchars_in = wchars_ff;
      wlen_in   = wlen_ff;
      qkind_in  = qkind_ff;
      esc_in    = esc_ff;
      used      = 1'b0;
      go        = 1'b0;
      idx       = pos_ff;
      slot_v    = '0;
      for (int k = 0; k < scl_pkg::PUSH_MAX; k++) begin
         slot[k] = mk(scl_pkg::T_WORD, pos_ff, pos_ff, 1'b1);
      end

      // resolve the held character against this word
      if (pend_ff != CH_NONE) begin
         pend_in = CH_NONE;
         if (pend_ff == CH_SLASH) begin
            if (!req.action && (c == CH_SLASH || c == CH_STAR)) begin
               if (mode_in == MODE_WORD) begin
                  slot[0]   = mk(keyword_type(wchars_in, wlen_in), tstart_in, pos_in, 1'b1);
                  slot_v[0] = 1'b1;
               end
               mode_in = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
               pos_in  = sat_inc(sat_inc(pos_in));
               used    = 1'b1;
            end else begin
               if (mode_in != MODE_WORD) begin
                  mode_in   = MODE_WORD;
                  tstart_in = pos_in;
                  wlen_in   = 4'd0;
               end
               if (wlen_in < 4'(KM)) wchars_in[wlen_in[KI-1:0]] = CH_SLASH;
               if (wlen_in < WLEN_MAX) wlen_in = wlen_in + 4'd1;
               pos_in = sat_inc(pos_in);
            end
         end else if (pend_ff == CH_BANG) begin
            slot_v[0] = 1'b1;
            if (!req.action && c == CH_EQ) begin
               slot[0] = mk(scl_pkg::T_NOTEQ, pos_in, sat_inc(sat_inc(pos_in)), 1'b1);
               pos_in  = sat_inc(sat_inc(pos_in));
               used    = 1'b1;
            end else begin
               slot[0] = mk(scl_pkg::T_NOT, pos_in, sat_inc(pos_in), 1'b1);
               pos_in  = sat_inc(pos_in);
            end
         end else begin
            slot_v[0] = 1'b1;
            if (!req.action && c == pend_ff) begin
               slot[0] = mk(double_type(pend_ff), pos_in, sat_inc(sat_inc(pos_in)), 1'b1);
               pos_in  = sat_inc(sat_inc(pos_in));
               used    = 1'b1;
            end else begin
               slot[0] = mk(single_type(pend_ff), pos_in, sat_inc(pos_in), 1'b1);
               pos_in  = sat_inc(pos_in);
            end
         end
      end

      if (req.action) begin
         if (mode_in == MODE_WORD) begin
            slot[1]   = mk(keyword_type(wchars_in, wlen_in), tstart_in, pos_in, 1'b1);
            slot_v[1] = 1'b1;
         end else if (mode_in == MODE_VAR) begin
            slot[1]   = mk(scl_pkg::T_VAR, tstart_in, pos_in, 1'b1);
            slot_v[1] = 1'b1;
         end else if (mode_in == MODE_STR) begin
            slot[1]   = mk(qkind_in ? scl_pkg::T_SQ : scl_pkg::T_DQ, tstart_in, pos_in, 1'b0);
            slot_v[1] = 1'b1;
         end
         slot[2]   = mk(scl_pkg::T_EOF, pos_in, pos_in, 1'b1);
         slot_v[2] = 1'b1;
         mode_in   = MODE_IDLE;
         pend_in   = CH_NONE;
         pos_in    = '0;
         tstart_in = '0;
         wlen_in   = 4'd0;
         qkind_in  = 1'b0;
         esc_in    = 1'b0;
      end else if (!used) begin
         idx = pos_in;
         go  = 1'b1;
         unique case (mode_in)
            MODE_STR: begin
               if (esc_in) begin
                  esc_in = 1'b0;
               end else if (c == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (c == (qkind_in ? CH_SQUOTE : CH_DQUOTE)) begin
                  slot[1]   = mk(qkind_in ? scl_pkg::T_SQ : scl_pkg::T_DQ, tstart_in,
                                 sat_inc(idx), 1'b1);
                  slot_v[1] = 1'b1;
                  mode_in   = MODE_IDLE;
               end
               pos_in = sat_inc(pos_in);
               go     = 1'b0;
            end
            MODE_LINE: begin
               if (c == CH_NL) mode_in = MODE_IDLE;
               pos_in = sat_inc(pos_in);
               go     = 1'b0;
            end
            MODE_BLOCK: begin
               if (c == CH_STAR) mode_in = MODE_BSTAR;
               pos_in = sat_inc(pos_in);
               go     = 1'b0;
            end
            MODE_BSTAR: begin
               if (c == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (c != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
               pos_in = sat_inc(pos_in);
               go     = 1'b0;
            end
            MODE_VAR: begin
               if (is_var_char(c)) begin
                  pos_in = sat_inc(pos_in);
                  go     = 1'b0;
               end else begin
                  slot[1]   = mk(scl_pkg::T_VAR, tstart_in, idx, 1'b1);
                  slot_v[1] = 1'b1;
                  mode_in   = MODE_IDLE;
               end
            end
            default: begin
            end
         endcase

         if (go) begin
            unique case (c) inside
               CH_SPACE, CH_TAB, CH_CR, CH_PIPE, CH_GT, CH_AMP, CH_EQ, CH_BANG,
               CH_LT, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
               CH_LBRACE, CH_RBRACE, CH_NL: begin
                  // close any open word
                  if (mode_in == MODE_WORD) begin
                     slot[1]   = mk(keyword_type(wchars_in, wlen_in), tstart_in, idx, 1'b1);
                     slot_v[1] = 1'b1;
                     mode_in   = MODE_IDLE;
                  end
                  if (c == CH_PIPE || c == CH_GT || c == CH_AMP || c == CH_EQ ||
                      c == CH_BANG) begin
                     pend_in = c;
                  end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                     pos_in = sat_inc(pos_in);
                  end else begin
                     slot[2]   = mk(single_type(c), idx, sat_inc(idx), 1'b1);
                     slot_v[2] = 1'b1;
                     pos_in    = sat_inc(pos_in);
                  end
               end
               CH_SLASH: begin
                  pend_in = c;
               end
               default: begin
                  if (mode_in != MODE_WORD &&
                      (c == CH_DOLLAR || c == CH_SQUOTE || c == CH_DQUOTE)) begin
                     tstart_in = idx;
                     if (c == CH_DOLLAR) begin
                        mode_in = MODE_VAR;
                     end else begin
                        mode_in  = MODE_STR;
                        qkind_in = (c == CH_SQUOTE);
                        esc_in   = 1'b0;
                     end
                  end else begin
                     if (mode_in != MODE_WORD) begin
                        mode_in   = MODE_WORD;
                        tstart_in = pos_in;
                        wlen_in   = 4'd0;
                     end
                     if (wlen_in < 4'(KM)) wchars_in[wlen_in[KI-1:0]] = c;
                     if (wlen_in < WLEN_MAX) wlen_in = wlen_in + 4'd1;
                  end
                  pos_in = sat_inc(pos_in);
               end
            endcase
         end
      end
   end

   // pack the tokens in order and mark the final one
   always_comb begin
      n     = 2'd0;
      items = '0;
      for (int k = 0; k < scl_pkg::PUSH_MAX; k++) begin
         if (slot_v[k]) begin
            items[n] = slot[k];
            n        = n + 2'd1;
         end
      end
      if (n != 2'd0) items[n - 2'd1].last = 1'b1;
      push.count = fire ? n : 2'd0;
      push.item  = items;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= CH_NONE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         wlen_ff   <= 4'd0;
         qkind_ff  <= 1'b0;
         esc_ff    <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         wlen_ff   <= wlen_in;
         qkind_ff  <= qkind_in;
         esc_ff    <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) wchars_ff <= wchars_in;
   end

endmodule
`default_nettype wire

/* rtl/scl_fifo.sv */
// Token queue: takes up to three tokens per cycle, hands out one per handshake.
`default_nettype none
module scl_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  scl_pkg::scl_push_type      push,
   output logic                       space_ok,
   scl_rsp_if.source                  rsp
);

   localparam int DEPTH = 8;
   localparam int AW    = $clog2(DEPTH);

   scl_pkg::scl_res_type mem_ff [DEPTH];
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [AW:0]          count_ff, count_in;
   logic                 pop;
   scl_pkg::scl_res_type head_word;

   assign head_word      = mem_ff[head_ff];
   assign rsp.valid      = (count_ff != '0);
   assign rsp.token_type = head_word.token_type;
   assign rsp.start_pos  = head_word.start_pos;
   assign rsp.end_pos    = head_word.end_pos;
   assign rsp.terminated = head_word.terminated;
   assign rsp.last       = head_word.last;

   assign pop      = rsp.valid & rsp.ready;
   assign space_ok = (count_ff <= (AW+1)'(DEPTH - scl_pkg::PUSH_MAX));
   assign head_in  = head_ff + AW'(pop);
   assign tail_in  = tail_ff + AW'(push.count);
   assign count_in = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < scl_pkg::PUSH_MAX; k++) begin
         if (2'(k) < push.count) mem_ff[tail_ff + AW'(k)] <= push.item[k];
      end
   end

endmodule
`default_nettype wire

/* rtl/scl_checker.sv */
// Port-level checks on the lexer's token output, bound to the top level.
`default_nettype none
module scl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_token_type,
   input wire logic [15:0] rsp_start_pos,
   input wire logic [15:0] rsp_end_pos,
   input wire logic        rsp_terminated,
   input wire logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_type) &&
      $stable(rsp_start_pos) && $stable(rsp_end_pos) && $stable(rsp_last))
      else $error("stalled token word changed");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == scl_pkg::T_EOF |->
      rsp_last && rsp_start_pos == rsp_end_pos)
      else $error("end-of-file token malformed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_end_pos >= rsp_start_pos)
      else $error("token ends before it starts");

   a_open_string: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_terminated |->
      (rsp_token_type == scl_pkg::T_DQ || rsp_token_type == scl_pkg::T_SQ))
      else $error("unterminated flag on a non-string token");

endmodule

bind shell_command_lexer_top scl_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_token_type (rsp_bus.token_type),
   .rsp_start_pos  (rsp_bus.start_pos),
   .rsp_end_pos    (rsp_bus.end_pos),
   .rsp_terminated (rsp_bus.terminated),
   .rsp_last       (rsp_bus.last)
);
`default_nettype wire

/* bench/shell_command_lexer_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the shell command lexer: token prediction, random idling, scoreboard.
module shell_command_lexer_top_tb;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 165;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int WLEN_LIMIT   = 15;
   localparam int KEYWORD_NUM  = 12;
   localparam longint unsigned POS_LIMIT = (64'd1 << scl_pkg::POS_WIDTH) - 1;
   localparam longint unsigned OUT_LIMIT = (64'd1 << scl_pkg::OUT_POS_WIDTH) - 1;

   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   typedef enum logic [3:0] {
      LX_IDLE, LX_WORD, LX_VAR, LX_STR, LX_LINE, LX_BLOCK, LX_BSTAR
   } lex_mode_e;

   localparam string WORD_POOL    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.-";
   localparam string VAR_POOL     = "abcXYZ0189_";
   localparam string STR_POOL     = "ab \\\"'$|/*\n";
   localparam string COMMENT_POOL = "ab */|\t";
   localparam string BLANK_POOL   = " \t\015";
   localparam string INWORD_POOL  = "$'\"/";

   logic clock = 1'b0;
   logic reset;

   scl_req_if req_bus ();
   scl_rsp_if rsp_bus ();

   shell_command_lexer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   string keyword_text [KEYWORD_NUM] = '{"while", "for", "if", "then", "else", "elif", "fi",
                                         "do", "done", "true", "false", "function"};
   string op_text [20] = '{"|", "||", ">", ">>", "&", "&&", "=", "==", "!", "!=", "<", ";",
                           "(", ")", "[", "]", "{", "}", "\n", "/"};

   lex_mode_e       mode;
   logic [7:0]      held;
   longint unsigned pos;
   longint unsigned tok_start;
   logic [7:0]      wbuf [scl_pkg::KEYWORD_MAX];
   int              wlen;
   bit              sq_kind;
   bit              esc;

   scl_pkg::scl_res_type step_toks [$];
   scl_pkg::scl_res_type token_q [$];
   logic [7:0]           char_q [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  items_sent  = 0;
   int  stall_left  = 0;
   bit  src_gaps_on = 1'b1;
   bit  sink_stalls_on = 1'b1;

   // ---------------------------------------------------------------- token prediction

   function automatic longint unsigned pos_inc(longint unsigned x);
      return (x >= POS_LIMIT) ? POS_LIMIT : x + 1;
   endfunction

   function automatic logic [scl_pkg::OUT_POS_WIDTH-1:0] out_pos(longint unsigned v);
      return scl_pkg::OUT_POS_WIDTH'((v > OUT_LIMIT) ? OUT_LIMIT : v);
   endfunction

   function automatic void lexer_clear();
      mode      = LX_IDLE;
      held      = 8'h00;
      pos       = 0;
      tok_start = 0;
      wlen      = 0;
      sq_kind   = 1'b0;
      esc       = 1'b0;
   endfunction

   function automatic void emit(logic [5:0] tt, longint unsigned s, longint unsigned e, bit term);
      scl_pkg::scl_res_type r;
      if (step_toks.size() >= scl_pkg::PUSH_MAX) return;
      r.token_type = tt;
      r.start_pos  = out_pos(s);
      r.end_pos    = out_pos(e);
      r.terminated = term;
      r.last       = 1'b0;
      step_toks.insert(step_toks.size(), r);
   endfunction

   function automatic bit is_var_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "_";
   endfunction

   function automatic logic [5:0] word_code();
      bit hit;
      int k;
      int j;
      for (k = 0; k < KEYWORD_NUM; k++) begin
         if (wlen == keyword_text[k].len() && wlen <= scl_pkg::KEYWORD_MAX) begin
            hit = 1'b1;
            for (j = 0; j < wlen; j++)
               if (wbuf[j] != keyword_text[k][j]) hit = 1'b0;
            if (hit) return scl_pkg::T_KW0 + 6'(k);
         end
      end
      return scl_pkg::T_WORD;
   endfunction

   function automatic void word_add(logic [7:0] c);
      if (mode != LX_WORD) begin
         mode      = LX_WORD;
         tok_start = pos;
         wlen      = 0;
      end
      if (wlen < scl_pkg::KEYWORD_MAX) wbuf[wlen] = c;
      if (wlen < WLEN_LIMIT) wlen++;
   endfunction

   function automatic void close_word(longint unsigned endp);
      if (mode == LX_WORD) begin
         emit(word_code(), tok_start, endp, 1'b1);
         mode = LX_IDLE;
      end
   endfunction

   function automatic logic [5:0] single_code(logic [7:0] c);
      case (c)
         ">":     return scl_pkg::T_GT;
         "<":     return scl_pkg::T_LT;
         ";":     return scl_pkg::T_SEMI;
         "(":     return scl_pkg::T_LPAR;
         ")":     return scl_pkg::T_RPAR;
         "[":     return scl_pkg::T_LBRK;
         "]":     return scl_pkg::T_RBRK;
         "{":     return scl_pkg::T_LBRC;
         "}":     return scl_pkg::T_RBRC;
         "|":     return scl_pkg::T_PIPE;
         "\n":    return scl_pkg::T_NL;
         "=":     return scl_pkg::T_EQ;
         "!":     return scl_pkg::T_NOT;
         default: return scl_pkg::T_WORD;
      endcase
   endfunction

   function automatic logic [5:0] pair_code(logic [7:0] c);
      case (c)
         "=":     return scl_pkg::T_EQEQ;
         "|":     return scl_pkg::T_OR;
         "&":     return scl_pkg::T_AND;
         ">":     return scl_pkg::T_GTGT;
         default: return scl_pkg::T_WORD;
      endcase
   endfunction

   function automatic bit resolve_held(logic [7:0] c, bit has_c);
      logic [7:0]      p;
      longint unsigned ps;
      p    = held;
      ps   = pos;
      held = 8'h00;
      if (p == "/") begin
         if (has_c && (c == "/" || c == "*")) begin
            close_word(ps);
            mode = (c == "/") ? LX_LINE : LX_BLOCK;
            pos  = pos_inc(pos_inc(pos));
            return 1'b1;
         end
         word_add("/");
         pos = pos_inc(pos);
         return 1'b0;
      end
      if (p == "!") begin
         if (has_c && c == "=") begin
            emit(scl_pkg::T_NOTEQ, ps, pos_inc(pos_inc(ps)), 1'b1);
            pos = pos_inc(pos_inc(pos));
            return 1'b1;
         end
         emit(scl_pkg::T_NOT, ps, pos_inc(ps), 1'b1);
         pos = pos_inc(pos);
         return 1'b0;
      end
      if (has_c && c == p) begin
         emit(pair_code(p), ps, pos_inc(pos_inc(ps)), 1'b1);
         pos = pos_inc(pos_inc(pos));
         return 1'b1;
      end
      emit(single_code(p), ps, pos_inc(ps), 1'b1);
      pos = pos_inc(pos);
      return 1'b0;
   endfunction

   function automatic void eat(logic [7:0] c);
      longint unsigned idx;
      idx = pos;
      case (mode)
         LX_STR: begin
            if (esc) begin
               esc = 1'b0;
            end else if (c == "\\") begin
               esc = 1'b1;
            end else if (c == (sq_kind ? "'" : "\"")) begin
               emit(sq_kind ? scl_pkg::T_SQ : scl_pkg::T_DQ, tok_start, pos_inc(idx), 1'b1);
               mode = LX_IDLE;
            end
            pos = pos_inc(pos);
            return;
         end
         LX_LINE: begin
            if (c == "\n") mode = LX_IDLE;
            pos = pos_inc(pos);
            return;
         end
         LX_BLOCK: begin
            if (c == "*") mode = LX_BSTAR;
            pos = pos_inc(pos);
            return;
         end
         LX_BSTAR: begin
            if (c == "/") mode = LX_IDLE;
            else if (c != "*") mode = LX_BLOCK;
            pos = pos_inc(pos);
            return;
         end
         LX_VAR: begin
            if (is_var_char(c)) begin
               pos = pos_inc(pos);
               return;
            end
            emit(scl_pkg::T_VAR, tok_start, idx, 1'b1);
            mode = LX_IDLE;
         end
         default: ;
      endcase
      case (c)
         " ", "\t", "\015": begin
            close_word(idx);
            pos = pos_inc(pos);
         end
         "$", "'", "\"": begin
            if (mode == LX_WORD) begin
               word_add(c);
            end else begin
               tok_start = idx;
               if (c == "$") begin
                  mode = LX_VAR;
               end else begin
                  mode    = LX_STR;
                  sq_kind = (c == "'");
                  esc     = 1'b0;
               end
            end
            pos = pos_inc(pos);
         end
         "/": held = c;
         "|", ">", "&", "=", "!": begin
            close_word(idx);
            held = c;
         end
         "<", ";", "(", ")", "[", "]", "{", "}", "\n": begin
            close_word(idx);
            emit(single_code(c), idx, pos_inc(idx), 1'b1);
            pos = pos_inc(pos);
         end
         default: begin
            word_add(c);
            pos = pos_inc(pos);
         end
      endcase
   endfunction

   function automatic void predict_word(logic act, logic [7:0] c);
      bit used;
      step_toks.delete();
      if (act == ACT_CHAR) begin
         used = 1'b0;
         if (held != 8'h00) used = resolve_held(c, 1'b1);
         if (!used) eat(c);
      end else begin
         if (held != 8'h00) void'(resolve_held(8'h00, 1'b0));
         case (mode)
            LX_WORD: close_word(pos);
            LX_VAR:  emit(scl_pkg::T_VAR, tok_start, pos, 1'b1);
            LX_STR:  emit(sq_kind ? scl_pkg::T_SQ : scl_pkg::T_DQ, tok_start, pos, 1'b0);
            default: ;
         endcase
         emit(scl_pkg::T_EOF, pos, pos, 1'b1);
         lexer_clear();
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
   endfunction

   // ---------------------------------------------------------------- input side

   task automatic send_word(logic act, logic [7:0] c);
      int gap;
      gap = src_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.ch     <= c;
      do @(posedge clock); while (!req_bus.ready);
      predict_word(act, c);
      items_sent++;
   endtask

   task automatic send_end();
      send_word(ACT_END, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] pick(string pool);
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   function automatic void add_text(string s);
      int k;
      for (k = 0; k < s.len(); k++) char_q.insert(char_q.size(), s[k]);
   endfunction

   function automatic void add_pick(string pool, int n);
      repeat (n) char_q.insert(char_q.size(), pick(pool));
   endfunction

   task automatic flush_text();
      while (char_q.size() != 0) send_word(ACT_CHAR, char_q.pop_front());
   endtask

   // ---------------------------------------------------------------- result side

   function automatic int stall_draw();
      return sink_stalls_on ? $urandom_range(0, 8) : 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) stall_left = stall_draw();
         else if (stall_left > 0) stall_left--;
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   task automatic report_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      scl_pkg::scl_res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (token_q.size() == 0) begin
            $error("token word with no expectation: token_type %0d", rsp_bus.token_type);
            error_count++;
         end else begin
            want = token_q.pop_front();
            report_field("token_type", want.token_type, rsp_bus.token_type);
            report_field("start_pos", want.start_pos, rsp_bus.start_pos);
            report_field("end_pos", want.end_pos, rsp_bus.end_pos);
            report_field("terminated", want.terminated, rsp_bus.terminated);
            report_field("last", want.last, rsp_bus.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_tokens();
      add_text("a$'/c&$v!=\"\\\"\"//z\n");
      flush_text();
      send_end();
   endtask

   task automatic test_directed_edges();
      send_word(ACT_CHAR, 8'h00);
      send_word(ACT_CHAR, 8'hFF);
      add_text(" /*/*/>");
      flush_text();
      send_end();
      add_text("fi 'a\\");
      flush_text();
      send_end();
   endtask

   task automatic test_random_streams();
      int    first_item;
      string s;
      logic  quote;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) src_gaps_on = !src_gaps_on;
         if ($urandom_range(0, 7) == 0) sink_stalls_on = !sink_stalls_on;
         case ($urandom_range(0, 11))
            0: begin
               add_text(keyword_text[$urandom_range(0, KEYWORD_NUM - 1)]);
               add_pick(BLANK_POOL, 1);
            end
            1: begin
               add_pick(WORD_POOL, $urandom_range(1, 11));
               if ($urandom_range(0, 3) == 0) begin
                  add_pick(INWORD_POOL, 1);
                  add_pick(WORD_POOL, $urandom_range(0, 3));
               end
            end
            2: begin
               add_text("$");
               add_pick(VAR_POOL, $urandom_range(0, 4));
            end
            3: begin
               quote = 1'($urandom_range(0, 1));
               s = quote ? "'" : "\"";
               add_text(s);
               add_pick(STR_POOL, $urandom_range(0, 6));
               if ($urandom_range(0, 5) != 0) add_text(s);
            end
            4: add_text(op_text[$urandom_range(0, 19)]);
            5: begin
               add_text("//");
               add_pick(COMMENT_POOL, $urandom_range(0, 4));
               add_text("\n");
            end
            6: begin
               add_text("/*");
               add_pick(COMMENT_POOL, $urandom_range(0, 5));
               add_text("*/");
            end
            7: add_pick(BLANK_POOL, $urandom_range(1, 3));
            8: repeat ($urandom_range(1, 3))
                  char_q.insert(char_q.size(), 8'($urandom_range(0, 255)));
            11: begin
               if ($urandom_range(0, 2) == 0) send_end();
               else add_text(" ");
            end
            default: add_text(" ");
         endcase
         flush_text();
      end
      send_end();
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_CHAR;
      req_bus.ch     <= 8'h00;
      lexer_clear();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_tokens();
      test_directed_edges();
      test_random_streams();

      req_bus.valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
